@@ rtl/hftc_pkg.sv @@
// Package of the frame type classifier: types, codes and header constants.
package hftc_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned KindW = 2;
	localparam int unsigned CountW = 3;

	localparam logic [ByteW-1:0] ForbiddenMask = 8'h80;
	localparam logic [ByteW-1:0] TypeMask = 8'h1F;
	localparam logic [ByteW-1:0] StartByte = 8'h01;
	localparam logic [4:0] NalSlice = 5'd1;
	localparam logic [4:0] NalIdr = 5'd5;
	localparam logic [4:0] NalSps = 5'd7;
	localparam logic [4:0] NalPps = 5'd8;
	localparam logic [CountW-1:0] CountMax = 3'd7;

	typedef enum logic [2:0] {
		PH_SEEK_FIRST = 3'd0,
		PH_SEEK_PPS   = 3'd1,
		PH_SEEK_IDR   = 3'd2,
		PH_UNKNOWN    = 3'd3,
		PH_P          = 3'd4,
		PH_I          = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		MODE_NONE  = 2'd0,
		MODE_THREE = 2'd1,
		MODE_FOUR  = 2'd2
	} mode_t;

	localparam logic [KindW-1:0] KIND_UNKNOWN = 2'd0;
	localparam logic [KindW-1:0] KIND_P = 2'd1;
	localparam logic [KindW-1:0] KIND_I = 2'd2;

	// One step of the parser: a byte moves on, and whether it ends the buffer.
	typedef struct packed {
		logic en;
		logic last;
	} step_t;

endpackage

@@ rtl/hftc_parser.sv @@
// Start code scanner and NAL header parser holding the per-buffer state.
module hftc_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hftc_pkg::step_t               step,
	input  logic [hftc_pkg::ByteW-1:0]    data_byte,
	output logic [hftc_pkg::KindW-1:0]    kind
);

	hftc_pkg::mode_t               mode_q, mode_n;
	hftc_pkg::phase_t              phase_q, phase_n;
	logic [hftc_pkg::ByteW-1:0]    hist0_q, hist1_q, hist2_q;
	logic [hftc_pkg::ByteW-1:0]    hist0_n, hist1_n, hist2_n;
	logic [hftc_pkg::CountW-1:0]   seen_q, seen_n, dist_q, dist_n;
	logic                          pend_valid_q, pend_valid_n;
	logic [hftc_pkg::ByteW-1:0]    pend_byte_q, pend_byte_n;
	logic                          hdr_next_q, hdr_next_n;
	logic                          header_done;
	logic                          sc3, sc4;

	function automatic hftc_pkg::phase_t take_header(input hftc_pkg::phase_t ph,
	                                                  input logic [7:0] hb);
		logic [4:0] t;
		hftc_pkg::phase_t r;
		t = hb[4:0];
		r = ph;
		if ((hb & hftc_pkg::ForbiddenMask) != '0) begin
			r = hftc_pkg::PH_UNKNOWN;
		end else begin
			unique case (ph)
				hftc_pkg::PH_SEEK_FIRST: begin
					if (t == hftc_pkg::NalSlice) r = hftc_pkg::PH_P;
					else if (t == hftc_pkg::NalSps) r = hftc_pkg::PH_SEEK_PPS;
					else r = hftc_pkg::PH_UNKNOWN;
				end
				hftc_pkg::PH_SEEK_PPS: begin
					r = (t == hftc_pkg::NalPps) ? hftc_pkg::PH_SEEK_IDR : hftc_pkg::PH_UNKNOWN;
				end
				hftc_pkg::PH_SEEK_IDR: begin
					if (t == hftc_pkg::NalIdr) r = hftc_pkg::PH_I;
				end
				default: r = ph;
			endcase
		end
		return r;
	endfunction

	assign sc3 = (hist1_q == '0) && (hist0_q == '0) && (data_byte == hftc_pkg::StartByte);
	assign sc4 = sc3 && (hist2_q == '0);

	// Next-state logic.
	always_comb begin
		mode_n = mode_q;
		phase_n = phase_q;
		pend_valid_n = pend_valid_q;
		pend_byte_n = pend_byte_q;
		hdr_next_n = hdr_next_q;
		header_done = 1'b0;
		if (phase_q == hftc_pkg::PH_SEEK_FIRST || phase_q == hftc_pkg::PH_SEEK_PPS ||
		    phase_q == hftc_pkg::PH_SEEK_IDR) begin
			if (pend_valid_q) begin
				phase_n = take_header(phase_q, pend_byte_q & hftc_pkg::TypeMask |
				                      pend_byte_q & hftc_pkg::ForbiddenMask);
				pend_valid_n = 1'b0;
				pend_byte_n = '0;
				header_done = 1'b1;
			end else if (hdr_next_q) begin
				pend_valid_n = 1'b1;
				pend_byte_n = data_byte;
				hdr_next_n = 1'b0;
			end else begin
				if (mode_q == hftc_pkg::MODE_NONE) begin
					if (seen_q == 3'd2 && sc3) mode_n = hftc_pkg::MODE_THREE;
					else if (seen_q == 3'd3 && sc4) mode_n = hftc_pkg::MODE_FOUR;
					else if (seen_q >= 3'd3) phase_n = hftc_pkg::PH_UNKNOWN;
				end
				if (mode_n == hftc_pkg::MODE_THREE) begin
					if (dist_q >= 3'd2 && sc3) hdr_next_n = 1'b1;
				end else if (mode_n == hftc_pkg::MODE_FOUR) begin
					if (dist_q >= 3'd3 && sc4) hdr_next_n = 1'b1;
				end
			end
		end
		hist2_n = hist1_q;
		hist1_n = hist0_q;
		hist0_n = data_byte;
		seen_n = (seen_q < hftc_pkg::CountMax) ? seen_q + 3'd1 : seen_q;
		if (header_done) dist_n = 3'd2;
		else dist_n = (dist_q < hftc_pkg::CountMax) ? dist_q + 3'd1 : dist_q;
	end

	// Result of the buffer as it stands after this byte.
	always_comb begin
		unique case (phase_n)
			hftc_pkg::PH_P: kind = hftc_pkg::KIND_P;
			hftc_pkg::PH_I: kind = hftc_pkg::KIND_I;
			default:        kind = hftc_pkg::KIND_UNKNOWN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= hftc_pkg::MODE_NONE;
			phase_q <= hftc_pkg::PH_SEEK_FIRST;
			hist0_q <= '0;
			hist1_q <= '0;
			hist2_q <= '0;
			seen_q <= '0;
			dist_q <= '0;
			pend_valid_q <= 1'b0;
			pend_byte_q <= '0;
			hdr_next_q <= 1'b0;
		end else if (step.en) begin
			mode_q <= mode_n;
			if (step.last) begin
				phase_q <= hftc_pkg::PH_SEEK_FIRST;
				hist0_q <= '0;
				hist1_q <= '0;
				hist2_q <= '0;
				seen_q <= '0;
				dist_q <= '0;
				pend_valid_q <= 1'b0;
				pend_byte_q <= '0;
				hdr_next_q <= 1'b0;
			end else begin
				phase_q <= phase_n;
				hist0_q <= hist0_n;
				hist1_q <= hist1_n;
				hist2_q <= hist2_n;
				seen_q <= seen_n;
				dist_q <= dist_n;
				pend_valid_q <= pend_valid_n;
				pend_byte_q <= pend_byte_n;
				hdr_next_q <= hdr_next_n;
			end
		end
	end

endmodule

@@ rtl/h264_frame_type_classifier.sv @@
// Top level of the frame type classifier: input register, parser and result register.
//
// The block reads an H.264 Annex B buffer one byte per item on the slave stream
// (s_tdata holds the byte, s_tlast marks the last byte of the buffer) and gives one
// item on the master stream for each buffer: the frame kind in m_tdata[1:0], where
// 0 is unknown, 1 a predicted frame and 2 an intra frame.
//
// A byte accepted from the slave stream sits in the input register and is parsed as it
// moves on; if it was the last byte, its result is loaded into the result register at
// that same edge, which raises m_tvalid. One byte is taken in every cycle unless a last
// byte is held back, and a new byte enters while the previous result still waits.
//
// The start-code length (three or four bytes) is learned on the first buffer that
// begins with a start code and is kept until reset. Reset clears the valid flags and all parser
// state, including the learned length, and leaves both streams empty.
//
// When the receiver stalls, the finished result is held in the result register;
// bytes that do not end a buffer keep flowing, and a last byte waits in the input
// register, which then drops s_tready until the result is taken.
module h264_frame_type_classifier (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // end_of_buffer
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [1:0] frame_kind, [7:2] zero
);

	logic                          valid_s1;
	logic                          last_s1;
	logic [hftc_pkg::ByteW-1:0]    byte_s1;
	logic                          advance;
	hftc_pkg::step_t               step;
	logic [hftc_pkg::KindW-1:0]    kind;
	logic [hftc_pkg::KindW-1:0]    kind_q;
	logic                          out_valid_q;

	// A byte that ends a buffer may only move on when the result register is free or its result is being taken.
	assign advance = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	assign step.en = advance;
	assign step.last = last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	hftc_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.kind      (kind)
	);

	// Result register: loaded at the last byte of a buffer, emptied when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			kind_q <= kind;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {6'b0, kind_q};

endmodule

@@ rtl/hftc_checker.sv @@
// Port checker of the frame type classifier, bound to the top level.
module hftc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,
	input logic       s_tlast,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn under stall");

	// A stalled result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed under stall");

	// Only the three defined kinds are ever given, with the padding clear.
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] != 2'b11) && (m_tdata[7:2] == 6'b0))
		else $error("illegal frame kind");

	// With the result register empty the input side never stalls.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with no pending result");

endmodule

bind h264_frame_type_classifier hftc_checker u_hftc_checker (.*);

@@ tb/sv/h264_frame_type_classifier_tb.sv @@
// Testbench of the frame type classifier: byte streams in, frame kinds checked against a predictor.
`timescale 1ns / 100ps

module h264_frame_type_classifier_tb;
	import hftc_pkg::*;

	localparam int unsigned ItemTarget = 1550;
	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned DirRows = 27;

	// One byte of a buffer as it is queued for the sender. Where typed is set, kind is
	// the frame kind written into the table by hand; otherwise the predictor decides.
	typedef struct packed {
		logic [ByteW-1:0] data;
		logic             last;
		logic             typed;
		logic [KindW-1:0] kind;
		logic             long_only;
	} stim_row_t;

	// Directed buffers. The leading zero of the learning buffer is only sent when the run
	// teaches the four-byte start code; without it the buffer is the short 00 00 01 case.
	localparam stim_row_t DIRECTED [DirRows] = '{
		// No start code while the length is unknown: unknown, nothing learned.
		'{8'hFF, 1'b1, 1'b1, KIND_UNKNOWN, 1'b0},
		// The learning buffer: a bare start code, so the header never arrives.
		'{8'h00, 1'b0, 1'b0, KIND_UNKNOWN, 1'b1},
		'{8'h00, 1'b0, 1'b0, KIND_UNKNOWN, 1'b0},
		'{8'h00, 1'b0, 1'b0, KIND_UNKNOWN, 1'b0},
		'{8'h01, 1'b1, 1'b1, KIND_UNKNOWN, 1'b0},
		// A single slice header followed by one byte: a predicted frame.
		'{8'h00, 1'b0, 1'b0, KIND_UNKNOWN, 1'b0},
		'{8'h00, 1'b0, 1'b0, KIND_UNKNOWN, 1'b0},
		'{8'h00, 1'b0, 1'b0, KIND_UNKNOWN, 1'b0},
		'{8'h01, 1'b0, 1'b0, KIND_UNKNOWN, 1'b0},
		'{8'h41, 1'b0, 1'b0, KIND_UNKNOWN, 1'b0},
		'{8'h00, 1'b1, 1'b0, KIND_UNKNOWN, 1'b0},
		// SPS, PPS and IDR, each start code opening on the byte after the header.
		'{8'h00, 1'b0, 1'b0, KIND_UNKNOWN, 1'b0},
		'{8'h00, 1'b0, 1'b0, KIND_UNKNOWN, 1'b0},
		'{8'h00, 1'b0, 1'b0, KIND_UNKNOWN, 1'b0},
		'{8'h01, 1'b0, 1'b0, KIND_UNKNOWN, 1'b0},
		'{8'h67, 1'b0, 1'b0, KIND_UNKNOWN, 1'b0},
		'{8'h00, 1'b0, 1'b0, KIND_UNKNOWN, 1'b0},
		'{8'h00, 1'b0, 1'b0, KIND_UNKNOWN, 1'b0},
		'{8'h00, 1'b0, 1'b0, KIND_UNKNOWN, 1'b0},
		'{8'h01, 1'b0, 1'b0, KIND_UNKNOWN, 1'b0},
		'{8'h68, 1'b0, 1'b0, KIND_UNKNOWN, 1'b0},
		'{8'h00, 1'b0, 1'b0, KIND_UNKNOWN, 1'b0},
		'{8'h00, 1'b0, 1'b0, KIND_UNKNOWN, 1'b0},
		'{8'h00, 1'b0, 1'b0, KIND_UNKNOWN, 1'b0},
		'{8'h01, 1'b0, 1'b0, KIND_UNKNOWN, 1'b0},
		'{8'h65, 1'b0, 1'b0, KIND_UNKNOWN, 1'b0},
		'{8'h00, 1'b1, 1'b0, KIND_UNKNOWN, 1'b0}
	};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata = 8'h00;   // [7:0] data_byte
	logic             s_tlast = 1'b0;    // end_of_buffer
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [7:0]       m_tdata;           // [1:0] frame_kind, [7:2] zero

	// Bytes waiting to be sent, and frame kinds waiting to come out.
	stim_row_t        byte_q[$];
	logic [KindW-1:0] kind_due_q[$];

	// Predictor state: a copy of what the parser keeps for the current buffer.
	mode_t            code_mode;
	logic [ByteW-1:0] recent [3];
	logic [CountW-1:0] seen_cnt;
	logic [CountW-1:0] search_dist;
	phase_t           phase;
	logic [ByteW:0]   held_hdr;
	bit               hdr_due;

	// Sender, receiver and bookkeeping.
	logic             cur_typed = 1'b0;
	logic [KindW-1:0] cur_kind = KIND_UNKNOWN;
	int unsigned      burst_left = 1;
	int unsigned      gap_left = 0;
	bit               rx_open = 1'b0;
	int unsigned      rx_left = 0;
	int unsigned      bytes_total = 0;
	int unsigned      bytes_in = 0;
	int unsigned      buffers_sent = 0;
	int unsigned      kinds_seen [3] = '{0, 0, 0};
	int unsigned      fault_count = 0;
	int unsigned      cycle_count = 0;
	bit               long_code;
	logic [KindW-1:0] predicted;
	logic [KindW-1:0] wanted;

	h264_frame_type_classifier DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// Works out what one accepted byte does to the parser. Returns 1 on the last byte of a
	// buffer, with the frame kind in kind; the buffer state is then cleared, but the
	// learned start-code length stays.
	function automatic bit predict_kind(input logic [ByteW-1:0] b, input logic last,
		output logic [KindW-1:0] kind);
		logic [ByteW-1:0] type_bits;
		logic [4:0] nal;
		bit header_taken;
		bit prefix_three;
		bit prefix_four;
		header_taken = 1'b0;
		kind = KIND_UNKNOWN;
		prefix_three = recent[1] == 8'h00 && recent[0] == 8'h00 && b == StartByte;
		prefix_four = prefix_three && recent[2] == 8'h00;
		if (phase == PH_SEEK_FIRST || phase == PH_SEEK_PPS || phase == PH_SEEK_IDR) begin
			if (held_hdr[ByteW]) begin
				// A byte has followed the header, so the header now counts.
				type_bits = held_hdr[ByteW-1:0] & TypeMask;
				nal = type_bits[4:0];
				if ((held_hdr[ByteW-1:0] & ForbiddenMask) != 8'h00) begin
					phase = PH_UNKNOWN;
				end else if (phase == PH_SEEK_FIRST) begin
					if (nal == NalSlice)
						phase = PH_P;
					else if (nal == NalSps)
						phase = PH_SEEK_PPS;
					else
						phase = PH_UNKNOWN;
				end else if (phase == PH_SEEK_PPS) begin
					phase = (nal == NalPps) ? PH_SEEK_IDR : PH_UNKNOWN;
				end else if (nal == NalIdr) begin
					phase = PH_I;
				end
				held_hdr = '0;
				header_taken = 1'b1;
			end else if (hdr_due) begin
				held_hdr = {1'b1, b};
				hdr_due = 1'b0;
			end else begin
				// The length is learned only from a start code at the very head of a buffer.
				if (code_mode == MODE_NONE) begin
					if (seen_cnt == 3'd2 && prefix_three)
						code_mode = MODE_THREE;
					else if (seen_cnt == 3'd3 && prefix_four)
						code_mode = MODE_FOUR;
					else if (seen_cnt >= 3'd3)
						phase = PH_UNKNOWN;
				end
				if (code_mode == MODE_THREE && search_dist >= 3'd2 && prefix_three)
					hdr_due = 1'b1;
				else if (code_mode == MODE_FOUR && search_dist >= 3'd3 && prefix_four)
					hdr_due = 1'b1;
			end
		end
		recent[2] = recent[1];
		recent[1] = recent[0];
		recent[0] = b;
		if (seen_cnt != CountMax)
			seen_cnt++;
		// The next search may start at the header byte, two bytes back.
		if (header_taken)
			search_dist = 3'd2;
		else if (search_dist != CountMax)
			search_dist++;
		if (!last)
			return 1'b0;
		if (phase == PH_P)
			kind = KIND_P;
		else if (phase == PH_I)
			kind = KIND_I;
		recent = '{8'h00, 8'h00, 8'h00};
		seen_cnt = '0;
		search_dist = '0;
		phase = PH_SEEK_FIRST;
		held_hdr = '0;
		hdr_due = 1'b0;
		return 1'b1;
	endfunction

	// Mostly zeros and start bytes, so that stray start codes turn up in the noise.
	function automatic logic [ByteW-1:0] noise_byte();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			return 8'h00;
		if (pick < 6)
			return StartByte;
		return 8'($urandom_range(0, 255));
	endfunction

	// Queues one random buffer. Most are chains of NAL units with real start codes and
	// random headers and payload; a few are pure noise or carry junk ahead of the first
	// start code. Three-byte start codes are mere noise once four bytes have been learned.
	task automatic add_random_buffer();
		logic [ByteW-1:0] frame_bytes[$];
		logic [4:0] plan[$];
		logic [ByteW-1:0] hdr;
		stim_row_t row;
		int unsigned pay;
		if ($urandom_range(0, 15) == 0) begin
			repeat ($urandom_range(1, 10))
				frame_bytes.push_back(noise_byte());
		end else begin
			case ($urandom_range(0, 5))
				0, 1: begin
					plan.push_back(NalSlice);
				end
				2, 3: begin
					plan.push_back(NalSps);
					plan.push_back(NalPps);
					plan.push_back(NalIdr);
				end
				4: begin
					plan.push_back(NalSps);
					plan.push_back(NalPps);
					plan.push_back(5'($urandom_range(0, 31)));
					plan.push_back(NalIdr);
				end
				default: begin
					repeat ($urandom_range(1, 4)) begin
						case ($urandom_range(0, 4))
							0: plan.push_back(NalSlice);
							1: plan.push_back(NalIdr);
							2: plan.push_back(NalSps);
							3: plan.push_back(NalPps);
							default: plan.push_back(5'($urandom_range(0, 31)));
						endcase
					end
				end
			endcase
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(1, 3))
					frame_bytes.push_back(noise_byte());
			end
			foreach (plan[i]) begin
				if ($urandom_range(0, 4) != 0)
					frame_bytes.push_back(8'h00);
				frame_bytes.push_back(8'h00);
				frame_bytes.push_back(8'h00);
				frame_bytes.push_back(StartByte);
				hdr = {($urandom_range(0, 15) == 0), 2'($urandom_range(0, 3)), plan[i]};
				frame_bytes.push_back(hdr);
				pay = $urandom_range(0, 3);
				// A final header with no payload ends the buffer only now and then; half such cases get one byte.
				if (i == plan.size() - 1 && pay == 0 && $urandom_range(0, 1) == 0)
					pay = 1;
				repeat (pay)
					frame_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end
		foreach (frame_bytes[i]) begin
			row = '{frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, KIND_UNKNOWN, 1'b0};
			byte_q.push_back(row);
		end
	endtask

	// Receiver: open and stalled windows of random length, with long open stretches.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_open = !rx_open;
				if (!rx_open)
					rx_left = $urandom_range(1, 12);
				else if ($urandom_range(0, 4) == 0)
					rx_left = $urandom_range(60, 150);
				else
					rx_left = $urandom_range(1, 20);
			end
			rx_left--;
			m_tready <= rx_open;
		end
	end

	// Sender, predictor and checker share one process, so that the result of an edge is
	// checked before the byte accepted at that same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
			s_tlast <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (kind_due_q.size() == 0) begin
					if (fault_count < 10)
						$display("%0t: frame kind %0d with no buffer outstanding",
							$realtime, m_tdata[1:0]);
					fault_count++;
				end else begin
					wanted = kind_due_q.pop_front();
					if (m_tdata[1:0] != wanted) begin
						if (fault_count < 10)
							$display("%0t: frame kind expected %0d, got %0d",
								$realtime, wanted, m_tdata[1:0]);
						fault_count++;
					end
					kinds_seen[wanted]++;
				end
			end

			if (s_tvalid && s_tready) begin
				bytes_in++;
				if (predict_kind(s_tdata, s_tlast, predicted)) begin
					kind_due_q.push_back(cur_typed ? cur_kind : predicted);
					buffers_sent++;
				end
			end

			// A new byte is put up only once the one on the bus has gone.
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0 || byte_q.size() == 0) begin
					s_tvalid <= 1'b0;
					if (gap_left != 0)
						gap_left--;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata <= byte_q[0].data;
					s_tlast <= byte_q[0].last;
					cur_typed <= byte_q[0].typed;
					cur_kind <= byte_q[0].kind;
					void'(byte_q.pop_front());
					burst_left--;
					if (burst_left == 0) begin
						if ($urandom_range(0, 3) == 0)
							burst_left = $urandom_range(20, 80);
						else
							burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CycleLimit) begin
			$display("timeout after %0d cycles, %0d of %0d bytes taken, %0d kinds outstanding",
				cycle_count, bytes_in, bytes_total, kind_due_q.size());
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		code_mode = MODE_NONE;
		recent = '{8'h00, 8'h00, 8'h00};
		seen_cnt = '0;
		search_dist = '0;
		phase = PH_SEEK_FIRST;
		held_hdr = '0;
		hdr_due = 1'b0;

		// The learned length lasts for the whole run, so the seed picks which one it is.
		long_code = $urandom_range(0, 1);
		foreach (DIRECTED[i]) begin
			if (long_code || !DIRECTED[i].long_only)
				byte_q.push_back(DIRECTED[i]);
		end
		while (byte_q.size() < ItemTarget)
			add_random_buffer();
		bytes_total = byte_q.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (bytes_in != bytes_total)
			@(posedge clk);
		while (kind_due_q.size() != 0)
			@(posedge clk);
		// Room for a stray late result to show up.
		repeat (10) @(posedge clk);

		$display("%0d bytes in %0d buffers, start code of %0d bytes learned",
			bytes_total, buffers_sent, long_code ? 4 : 3);
		$display("frame kinds checked: %0d unknown, %0d predicted, %0d intra; %0d faults",
			kinds_seen[KIND_UNKNOWN], kinds_seen[KIND_P], kinds_seen[KIND_I], fault_count);
		if (fault_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
